### sv/bpc_pkg.sv
// Shared constants and types of the barometric pressure compensation block.
package bpc_pkg;

  localparam int unsigned CountBitsDef = 10;
  localparam int unsigned WordW        = 16;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned PressW       = 11;
  localparam int unsigned TempW        = 12;
  localparam int unsigned PipeDepth    = 6;

  typedef enum logic [CfgIdxW-1:0] {
    CfgOffset     = 2'd0,
    CfgPressSlope = 2'd1,
    CfgTempSlope  = 2'd2,
    CfgCross      = 2'd3
  } cfg_idx_e;

  // Q24 polynomial scalings of the coefficients
  localparam int unsigned OffsetShift    = 21;
  localparam int unsigned PressSlopeShft = 11;
  localparam int unsigned TempSlopeShft  = 10;

  // Pcomp saturation and pressure scaling: 800 + round(Pcomp * 1040 / 1023)
  localparam int unsigned PcompW         = 34;
  localparam logic [PcompW-1:0] PcompMax = PcompW'(64'd1023 << 24);
  localparam int unsigned PressMulW      = 45;
  localparam int unsigned PressMul       = 1040;
  localparam logic [PressMulW-1:0] PressBias = PressMulW'(64'd1023 << 23);
  localparam int unsigned PressFracBits  = 24;
  localparam int unsigned PressYW        = 21;
  localparam int unsigned PressDiv       = 1023;
  localparam int unsigned PressRecip     = 1025;
  localparam int unsigned PressRecipShft = 20;
  localparam int unsigned PressRecipW    = 11;
  localparam int unsigned PressBase      = 800;

  // Temperature: 400 - round((T - 498) * 320 / 107), half away from zero
  localparam int unsigned TempOffsetCnt  = 498;
  localparam int unsigned TempScale      = 640;
  localparam int unsigned TempRndBias    = 107;
  localparam int unsigned TempDiv        = 214;
  localparam int unsigned TempRecipW     = 25;
  localparam logic [TempRecipW-1:0] TempRecip = 25'd20069940;
  localparam int unsigned TempRecipShft  = 32;
  localparam int unsigned TempBase       = 400;
  localparam int signed   TempMax        = 2047;
  localparam int signed   TempMin        = -2048;

endpackage

### sv/barometric_pressure_compensation_top.sv
// Top level: six-stage compensation pipeline for pressure and temperature counts.
//
// One item per clock: an item accepted at a clock edge moves through the stage
// registers and shows its result with result_valid_o high for one cycle; the
// result is taken at the edge that ends that strobe. busy_o is always low, so
// every start_i pulse is an accepted item. Results cannot be held off; the
// receiver must take each one in its strobe cycle.
// The stage count follows the multiplier chain: temperature products, slope
// times pressure count, Pcomp scaling and two reciprocal divisions. Write the
// coefficient registers only while no item is in flight.
module barometric_pressure_compensation_top #(
  parameter int unsigned COUNT_BITS = bpc_pkg::CountBitsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic [bpc_pkg::WordW-1:0]            pressure_word_i,
  input  logic [bpc_pkg::WordW-1:0]            temperature_word_i,
  input  logic                                 cfg_we_i,
  input  logic [bpc_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  logic [bpc_pkg::WordW-1:0]            cfg_wdata_i,
  output logic                                 result_valid_o,
  output logic [bpc_pkg::PressW-1:0]           pressure_kpa_q4_o,
  output logic signed [bpc_pkg::TempW-1:0]     temperature_c_q4_o,
  output logic                                 compensation_clipped_o
);
  import bpc_pkg::*;

  localparam int unsigned CB    = COUNT_BITS;
  localparam int unsigned CT_W  = WordW + CB + 1;
  localparam int unsigned SL_W  = ((CT_W > WordW + PressSlopeShft) ? CT_W
                                   : WordW + PressSlopeShft) + 1;
  localparam int unsigned PR_W  = SL_W + CB + 1;
  localparam int unsigned OF_A  = WordW + OffsetShift;
  localparam int unsigned OF_B  = CT_W + TempSlopeShft;
  localparam int unsigned PC_W0 = (OF_A > OF_B) ? OF_A : OF_B;
  localparam int unsigned PC_W  = ((PC_W0 > PR_W) ? PC_W0 : PR_W) + 2;
  localparam int unsigned E_W   = ((CB > 9) ? CB : 9) + 2;
  localparam int unsigned Z_W   = E_W + 10;
  localparam int unsigned TP_W  = Z_W + TempRecipW;
  localparam int unsigned Q_W   = Z_W - 7;
  localparam int unsigned TQ_W  = Q_W + 2;
  localparam int unsigned PY_W  = PressYW + PressRecipW;

  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // coefficient registers
  logic [WordW-1:0] coeff_offset_q, coeff_press_slope_q, coeff_temp_slope_q, coeff_cross_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_offset_q      <= '0;
      coeff_press_slope_q <= '0;
      coeff_temp_slope_q  <= '0;
      coeff_cross_q       <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgOffset:     coeff_offset_q      <= cfg_wdata_i;
        CfgPressSlope: coeff_press_slope_q <= cfg_wdata_i;
        CfgTempSlope:  coeff_temp_slope_q  <= cfg_wdata_i;
        CfgCross:      coeff_cross_q       <= cfg_wdata_i;
        default:       coeff_offset_q      <= coeff_offset_q;
      endcase
    end
  end

  // valid bits
  logic [PipeDepth-1:0] vld_q, vld_d;
  assign vld_d = {vld_q[PipeDepth-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // stage 1: counts, temperature products, temperature dividend
  logic [CB-1:0]          p_cnt, t_cnt;
  logic signed [CB:0]     t_s;
  logic signed [E_W-1:0]  e_d;
  logic [E_W-2:0]         e_abs;
  logic signed [CT_W-1:0] s1_ct_d, s1_bt_d, s1_ct_q, s1_bt_q;
  logic [Z_W-1:0]         s1_z_d, s1_z_q;
  logic [CB-1:0]          s1_p_q;
  logic                   s1_neg_q;

  assign p_cnt   = pressure_word_i[WordW-1 -: CB];
  assign t_cnt   = temperature_word_i[WordW-1 -: CB];
  assign t_s     = $signed({1'b0, t_cnt});
  assign s1_ct_d = CT_W'($signed(coeff_cross_q)) * CT_W'(t_s);
  assign s1_bt_d = CT_W'($signed(coeff_temp_slope_q)) * CT_W'(t_s);
  assign e_d     = $signed(E_W'(t_cnt)) - $signed(E_W'(TempOffsetCnt));
  assign e_abs   = e_d[E_W-1] ? (E_W-1)'(-e_d) : e_d[E_W-2:0];
  assign s1_z_d  = Z_W'(e_abs) * Z_W'(TempScale) + Z_W'(TempRndBias);

  always_ff @(posedge clk_i) begin
    s1_p_q   <= p_cnt;
    s1_ct_q  <= s1_ct_d;
    s1_bt_q  <= s1_bt_d;
    s1_z_q   <= s1_z_d;
    s1_neg_q <= e_d[E_W-1];
  end

  // stage 2: slope, offset terms, temperature reciprocal product
  logic signed [SL_W-1:0] s2_slope_d, s2_slope_q;
  logic signed [PC_W-1:0] s2_off_d, s2_off_q;
  logic [TP_W-1:0]        s2_tp;
  logic [Q_W-1:0]         s2_qe_q;
  logic [Z_W-1:0]         s2_z_q;
  logic [CB-1:0]          s2_p_q;
  logic                   s2_neg_q;

  assign s2_slope_d = (SL_W'($signed(coeff_press_slope_q)) <<< PressSlopeShft)
                    + SL_W'(s1_ct_q);
  assign s2_off_d   = (PC_W'($signed(coeff_offset_q)) <<< OffsetShift)
                    + (PC_W'(s1_bt_q) <<< TempSlopeShft);
  assign s2_tp      = TP_W'(s1_z_q) * TP_W'(TempRecip);

  always_ff @(posedge clk_i) begin
    s2_slope_q <= s2_slope_d;
    s2_off_q   <= s2_off_d;
    s2_qe_q    <= s2_tp[TempRecipShft +: Q_W];
    s2_z_q     <= s1_z_q;
    s2_p_q     <= s1_p_q;
    s2_neg_q   <= s1_neg_q;
  end

  // stage 3: Pcomp, temperature quotient correction
  logic signed [PR_W-1:0] s3_prod;
  logic signed [PC_W-1:0] s3_pc_d, s3_pc_q;
  logic [Z_W-1:0]         s3_r;
  logic [Q_W-1:0]         s3_q_d, s3_q_q;
  logic                   s3_neg_q;

  assign s3_prod = PR_W'(s2_slope_q) * PR_W'($signed({1'b0, s2_p_q}));
  assign s3_pc_d = s2_off_q + PC_W'(s3_prod);
  assign s3_r    = s2_z_q - Z_W'(s2_qe_q) * Z_W'(TempDiv);
  assign s3_q_d  = s2_qe_q + Q_W'(s3_r >= Z_W'(TempDiv));

  always_ff @(posedge clk_i) begin
    s3_pc_q  <= s3_pc_d;
    s3_q_q   <= s3_q_d;
    s3_neg_q <= s2_neg_q;
  end

  // stage 4: saturate Pcomp and scale, finish temperature
  logic                   pc_neg, pc_over;
  logic [PcompW-1:0]      pcs;
  logic [PressMulW-1:0]   px;
  logic [PressYW-1:0]     s4_y_q;
  logic                   s4_clip_q;
  logic signed [TQ_W-1:0] tq;
  logic signed [TempW-1:0] s4_t_d, s4_t_q;

  assign pc_neg  = s3_pc_q[PC_W-1];
  assign pc_over = !pc_neg && (s3_pc_q > $signed(PC_W'(PcompMax)));
  assign pcs     = pc_neg ? '0 : (pc_over ? PcompMax : s3_pc_q[PcompW-1:0]);
  assign px      = PressMulW'(pcs) * PressMulW'(PressMul) + PressBias;
  assign tq      = s3_neg_q ? ($signed(TQ_W'(TempBase)) + $signed(TQ_W'(s3_q_q)))
                            : ($signed(TQ_W'(TempBase)) - $signed(TQ_W'(s3_q_q)));

  always_comb begin
    priority if (tq > $signed(TQ_W'(TempMax))) begin
      s4_t_d = TempW'(TempMax);
    end else if (tq < $signed(TQ_W'(TempMin))) begin
      s4_t_d = TempW'(TempMin);
    end else begin
      s4_t_d = tq[TempW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    s4_y_q    <= px[PressFracBits +: PressYW];
    s4_clip_q <= pc_neg || pc_over;
    s4_t_q    <= s4_t_d;
  end

  // stage 5: pressure reciprocal product
  logic [PY_W-1:0]        py;
  logic [PressRecipW-1:0] s5_qe_q;
  logic [PressYW-1:0]     s5_y_q;
  logic                   s5_clip_q;
  logic signed [TempW-1:0] s5_t_q;

  assign py = PY_W'(s4_y_q) * PY_W'(PressRecip);

  always_ff @(posedge clk_i) begin
    s5_qe_q   <= py[PressRecipShft +: PressRecipW];
    s5_y_q    <= s4_y_q;
    s5_clip_q <= s4_clip_q;
    s5_t_q    <= s4_t_q;
  end

  // stage 6: quotient correction, output register
  logic [PressYW-1:0] s6_r;
  logic [PressW-1:0]  s6_p_d;

  assign s6_r   = s5_y_q - PressYW'(s5_qe_q) * PressYW'(PressDiv);
  assign s6_p_d = PressW'(PressBase) + PressW'(s5_qe_q)
                + PressW'(s6_r >= PressYW'(PressDiv));

  always_ff @(posedge clk_i) begin
    pressure_kpa_q4_o      <= s6_p_d;
    temperature_c_q4_o     <= s5_t_q;
    compensation_clipped_o <= s5_clip_q;
  end

  assign result_valid_o = vld_q[PipeDepth-1];

endmodule

### sv/bpc_checker.sv
// Port-level checker for the compensation block, with its bind statement.
module bpc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             start_i,
  input logic                             busy_o,
  input logic                             result_valid_o,
  input logic [bpc_pkg::PressW-1:0]       pressure_kpa_q4_o,
  input logic                             compensation_clipped_o
);
  import bpc_pkg::*;

  localparam int unsigned UpW = $clog2(PipeDepth + 1);

  logic [UpW-1:0] up_q, up_d;

  assign up_d = (up_q == UpW'(PipeDepth)) ? up_q : up_q + UpW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q <= '0;
    end else begin
      up_q <= up_d;
    end
  end

  a_item_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##PipeDepth result_valid_o)
    else $error("accepted item gave no result");

  a_result_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && up_q == UpW'(PipeDepth)) |-> $past(start_i && !busy_o, PipeDepth))
    else $error("result without an accepted item");

  a_pressure_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (pressure_kpa_q4_o >= PressW'(PressBase)
                        && pressure_kpa_q4_o <= PressW'(PressBase + PressMul)))
    else $error("pressure out of range");

  a_clip_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && compensation_clipped_o) |->
      (pressure_kpa_q4_o == PressW'(PressBase)
       || pressure_kpa_q4_o == PressW'(PressBase + PressMul)))
    else $error("clipped item not at a pressure limit");

endmodule

bind barometric_pressure_compensation_top bpc_checker u_bpc_checker (
  .clk_i                  (clk_i),
  .rst_ni                 (rst_ni),
  .start_i                (start_i),
  .busy_o                 (busy_o),
  .result_valid_o         (result_valid_o),
  .pressure_kpa_q4_o      (pressure_kpa_q4_o),
  .compensation_clipped_o (compensation_clipped_o)
);

### test/tb_top.sv
// Self-checking testbench for the barometric pressure compensation pipeline.

typedef struct packed {
  logic [bpc_pkg::PressW-1:0]       press;
  logic signed [bpc_pkg::TempW-1:0] temp;
  logic                             clip;
} reading_t;

class pressure_scoreboard;
  logic [bpc_pkg::WordW-1:0] coeff [4];
  reading_t    expected_q [$];
  int unsigned n_items;
  int unsigned n_results;
  int unsigned n_clipped;
  int unsigned n_errors;

  function new();
    foreach (coeff[i]) coeff[i] = '0;
    n_items   = 0;
    n_results = 0;
    n_clipped = 0;
    n_errors  = 0;
  endfunction

  function void set_coeff(bpc_pkg::cfg_idx_e idx, logic [bpc_pkg::WordW-1:0] val);
    coeff[idx] = val;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // Predict the compensated reading for one accepted sample.
  function void note_item(logic [bpc_pkg::WordW-1:0] pw, logic [bpc_pkg::WordW-1:0] tw);
    longint   p, t, a0, b1, b2, c12, slope, pc, full, pq, d, q, tq;
    bit       clip;
    reading_t r;
    p    = longint'(pw >> (bpc_pkg::WordW - bpc_pkg::CountBitsDef));
    t    = longint'(tw >> (bpc_pkg::WordW - bpc_pkg::CountBitsDef));
    a0   = longint'($signed(coeff[bpc_pkg::CfgOffset]));
    b1   = longint'($signed(coeff[bpc_pkg::CfgPressSlope]));
    b2   = longint'($signed(coeff[bpc_pkg::CfgTempSlope]));
    c12  = longint'($signed(coeff[bpc_pkg::CfgCross]));
    full = 64'sd1023 <<< 24;
    slope = b1 * 2048 + c12 * t;
    pc    = a0 * 2097152 + slope * p + b2 * 1024 * t;
    clip  = 1'b0;
    if (pc < 0) begin
      pc   = 0;
      clip = 1'b1;
    end
    if (pc > full) begin
      pc   = full;
      clip = 1'b1;
    end
    pq = 800 + (pc * 1040 + full / 2) / full;
    d  = (t - 498) * 320;
    q  = (d >= 0) ? (d * 2 + 107) / 214 : -((-d * 2 + 107) / 214);
    tq = 400 - q;
    if (tq > 2047) tq = 2047;
    if (tq < -2048) tq = -2048;
    r.press = pq[bpc_pkg::PressW-1:0];
    r.temp  = tq[bpc_pkg::TempW-1:0];
    r.clip  = clip;
    expected_q.push_back(r);
    n_items++;
  endfunction

  function void check_result(logic [bpc_pkg::PressW-1:0] press,
                             logic signed [bpc_pkg::TempW-1:0] temp, logic clip);
    reading_t e;
    n_results++;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result, expected none actual press %0d temp %0d clip %0b",
               $time, press, temp, clip);
      n_errors++;
      return;
    end
    e = expected_q.pop_front();
    if (clip) n_clipped++;
    if (press !== e.press) begin
      $display("%0t: pressure_kpa_q4 mismatch, expected %0d actual %0d",
               $time, e.press, press);
      n_errors++;
    end
    if (temp !== e.temp) begin
      $display("%0t: temperature_c_q4 mismatch, expected %0d actual %0d",
               $time, e.temp, temp);
      n_errors++;
    end
    if (clip !== e.clip) begin
      $display("%0t: compensation_clipped mismatch, expected %0b actual %0b",
               $time, e.clip, clip);
      n_errors++;
    end
  endfunction
endclass

module tb_top;
  import bpc_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandPhases = 10;
  localparam int unsigned PhaseItems = 125;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start_i;
  logic                     busy_o;
  logic [WordW-1:0]         pressure_word_i;
  logic [WordW-1:0]         temperature_word_i;
  logic                     cfg_we_i;
  logic [CfgIdxW-1:0]       cfg_idx_i;
  logic [WordW-1:0]         cfg_wdata_i;
  logic                     result_valid_o;
  logic [PressW-1:0]        pressure_kpa_q4_o;
  logic signed [TempW-1:0]  temperature_c_q4_o;
  logic                     compensation_clipped_o;

  pressure_scoreboard sb;
  bit          idle_on;
  int unsigned n_phases;

  barometric_pressure_compensation_top #(
    .COUNT_BITS(CountBitsDef)
  ) DUT (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .start_i               (start_i),
    .busy_o                (busy_o),
    .pressure_word_i       (pressure_word_i),
    .temperature_word_i    (temperature_word_i),
    .cfg_we_i              (cfg_we_i),
    .cfg_idx_i             (cfg_idx_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .result_valid_o        (result_valid_o),
    .pressure_kpa_q4_o     (pressure_kpa_q4_o),
    .temperature_c_q4_o    (temperature_c_q4_o),
    .compensation_clipped_o(compensation_clipped_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      sb.check_result(pressure_kpa_q4_o, temperature_c_q4_o, compensation_clipped_o);
    end
  end

  // Write all four coefficients; call at a falling edge with the pipeline empty.
  task automatic load_coeffs(logic [WordW-1:0] a0, logic [WordW-1:0] b1,
                             logic [WordW-1:0] b2, logic [WordW-1:0] c12);
    logic [WordW-1:0] vals [4];
    cfg_idx_e         idx;
    vals = '{a0, b1, b2, c12};
    idx  = CfgOffset;
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx;
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
      sb.set_coeff(idx, vals[i]);
      @(negedge clk_i);
      idx = idx.next();
    end
    cfg_we_i <= 1'b0;
    n_phases++;
  endtask

  // Offer one sample, wait for acceptance, return at the next falling edge.
  task automatic send_item(logic [WordW-1:0] pw, logic [WordW-1:0] tw);
    while (idle_on && $urandom_range(99) < 37) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i            <= 1'b1;
    pressure_word_i    <= pw;
    temperature_word_i <= tw;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_item(pw, tw);
    @(negedge clk_i);
  endtask

  // Stop sending and hold until every pending reading has come back.
  task automatic drain();
    start_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (PipeDepth + 2) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [WordW-1:0] pick_extreme();
    logic [WordW-1:0] ext [5];
    ext = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'hFFFF};
    return ext[3'($urandom_range(4))];
  endfunction

  function automatic logic [WordW-1:0] pick_signed(int lim);
    int v;
    v = $urandom_range(2 * lim) - lim;
    return v[WordW-1:0];
  endfunction

  initial begin
    sb                 = new();
    idle_on            = 1'b1;
    n_phases           = 0;
    rst_ni             = 1'b0;
    start_i            = 1'b0;
    pressure_word_i    = '0;
    temperature_word_i = '0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CfgOffset;
    cfg_wdata_i        = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset coefficients: Pcomp exactly zero, temperature extremes and midpoint
    send_item(16'h0000, 16'h0000);
    send_item(16'hFFFF, 16'hFFFF);
    send_item(16'h8000, 16'h7C80);
    send_item(16'h003F, 16'h7C7F);
    send_item(16'hFFC0, 16'h7CFF);
    drain();
    // Pcomp exactly full scale, then just above it
    load_coeffs(16'd8184, 16'h0000, 16'h0000, 16'h0000);
    send_item(16'h1234, 16'hABCD);
    send_item(16'hFFFF, 16'h0000);
    drain();
    load_coeffs(16'd8185, 16'h0000, 16'h0000, 16'h0000);
    send_item(16'h0000, 16'hFFFF);
    drain();
    // negative offset clips low
    load_coeffs(16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
    send_item(16'h5555, 16'hAAAA);
    drain();
    // pressure rounding tie through the temperature slope
    load_coeffs(16'h0000, 16'h0000, 16'd512, 16'h0000);
    send_item(16'h0000, 16'hFFC0);
    send_item(16'hFFFF, 16'hFFFF);
    drain();
    // same tie through the cross term
    load_coeffs(16'h0000, 16'h0000, 16'h0000, 16'd16384);
    send_item(16'h0800, 16'hFFC0);
    drain();
    load_coeffs(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_item(16'hFFFF, 16'hFFFF);
    send_item(16'h0000, 16'h0000);
    drain();
    load_coeffs(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_item(16'hFFFF, 16'hFFFF);
    send_item(16'h0000, 16'h0000);
    send_item(16'hFFFF, 16'h0000);
    drain();

    for (int ph = 0; ph < RandPhases; ph++) begin
      unique case (ph % 4)
        0, 1: begin
          load_coeffs(WordW'($urandom_range(8184)), pick_signed(4096), pick_signed(4096),
                      pick_signed(8192));
        end
        2: begin
          load_coeffs(WordW'($urandom), WordW'($urandom), WordW'($urandom),
                      WordW'($urandom));
        end
        default: begin
          load_coeffs(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme());
        end
      endcase
      idle_on = (ph != 4);
      for (int n = 0; n < PhaseItems; n++) begin
        send_item(WordW'($urandom), WordW'($urandom));
      end
      drain();
    end
    idle_on = 1'b1;

    $display("Covered %0d samples over %0d coefficient settings, %0d readings back",
             sb.n_items, n_phases + 1, sb.n_results);
    $display("%0d readings saturated the polynomial", sb.n_clipped);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
